// File: rtl/bmhq_pkg.sv
`default_nettype none

package bmhq_pkg;

  // Capacity register
  localparam int unsigned CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Request codes; any other code behaves as a peek
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_PEEK   = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_LAST,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// File: rtl/bmhq_ram.sv
`default_nettype none

module bmhq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/binary_min_heap_queue_top.sv
`default_nettype none

// Binary min-heap priority queue of signed keys.
// Command channel: drive in_req_type and in_key with start; the item is
// taken at a clock edge where start is high and busy is low. Insert places
// a key, remove takes the minimum, peek (or the unused code) reports it.
// Result channel: out_valid is high for one cycle with out_value, out_status
// and out_count; the receiver cannot stall it and must take it then.
// Configuration: cfg_we with cfg_data writes the capacity limit; write it
// only while the block is idle. Reset sets the limit to 64 and empties the
// heap; no clearing pass is needed as only held entries are ever read.
// Sequence: peek, overflow, underflow and a remove that empties the heap
// go straight to the finishing step. An insert reads the parent and
// compares at each level it climbs, and settles at the root if it gets
// there; a remove takes the last entry as the key, then at each level
// reads the left and right children and compares, until the key settles.
// The rate is set by the store's single read port: each level of the sift
// needs one read (two for the children on the way down), each followed by
// a compare. busy stays high until the result is issued, and a new item
// may be taken in the cycle that out_valid is high.
module binary_min_heap_queue_top #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_req_type,
  input  wire logic signed [KEY_WIDTH-1:0]       in_key,
  output logic                                   out_valid,
  output logic signed [KEY_WIDTH-1:0]            out_value,
  output logic [1:0]                             out_status,
  output logic [$clog2(DEPTH):0]                 out_count,
  input  wire logic                              cfg_we,
  input  wire logic [bmhq_pkg::CAP_W-1:0]        cfg_data
);

  import bmhq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned MW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [MW-1:0] DEPTH_M = MW'(DEPTH);

  state_t state_r, state_nxt;

  logic [CAP_W-1:0]            cap_r;
  logic [CW-1:0]               count_r, count_nxt;
  logic [AW-1:0]               pos_r, pos_nxt;
  logic signed [KEY_WIDTH-1:0] k_r, k_nxt;
  logic signed [KEY_WIDTH-1:0] best_r, best_nxt;
  logic [AW-1:0]               sm_r, sm_nxt;
  logic                        moved_r, moved_nxt;
  logic                        r_ok_r, r_ok_nxt;
  logic signed [KEY_WIDTH-1:0] root_r;
  logic signed [KEY_WIDTH-1:0] rem_val_r, rem_val_nxt;
  logic                        take_rem_r, take_rem_nxt;
  logic [1:0]                  status_r, status_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic signed [KEY_WIDTH-1:0] out_value_r, out_value_nxt;
  logic [1:0]                  out_status_r, out_status_nxt;
  logic [CW-1:0]               out_count_r, out_count_nxt;

  logic                        we;
  logic [AW-1:0]               waddr;
  logic [KEY_WIDTH-1:0]        wdata;
  logic [AW-1:0]               raddr;
  logic [KEY_WIDTH-1:0]        rdata;
  logic signed [KEY_WIDTH-1:0] rdata_s;

  logic [AW-1:0] parent;
  logic [CW:0]   left_idx;
  logic [CW:0]   right_idx;
  logic          full;
  logic          accept;

  bmhq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rdata_s   = $signed(rdata);
  assign parent    = (pos_r - AW'(1)) >> 1;
  assign left_idx  = {pos_r, 1'b1} + (CW+1)'(0);
  assign right_idx = {pos_r, 1'b1} + (CW+1)'(1);
  // Effective capacity is the limit saturated to the store depth
  assign full      = (MW'(count_r) >= MW'(cap_r)) || (MW'(count_r) >= DEPTH_M);
  assign accept    = start && (state_r == ST_IDLE);

  // Next state, store access and result
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    k_nxt          = k_r;
    best_nxt       = best_r;
    sm_nxt         = sm_r;
    moved_nxt      = moved_r;
    r_ok_nxt       = r_ok_r;
    rem_val_nxt    = rem_val_r;
    take_rem_nxt   = take_rem_r;
    status_nxt     = status_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    we             = 1'b0;
    waddr          = pos_r;
    wdata          = k_r;
    raddr          = pos_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          take_rem_nxt = 1'b0;
          status_nxt   = STATUS_OK;
          state_nxt    = ST_FINISH;
          if (in_req_type == REQ_INSERT) begin
            if (full) begin
              status_nxt = STATUS_OVERFLOW;
            end else begin
              k_nxt     = in_key;
              pos_nxt   = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
              state_nxt = ST_UP_RD;
            end
          end else if (in_req_type == REQ_REMOVE) begin
            if (count_r == '0) begin
              status_nxt = STATUS_UNDERFLOW;
            end else begin
              take_rem_nxt = 1'b1;
              rem_val_nxt  = root_r;
              count_nxt    = count_r - CW'(1);
              raddr        = count_nxt[AW-1:0];
              if (count_nxt != '0) begin
                state_nxt = ST_LAST;
              end
            end
          end else if (count_r == '0) begin
            status_nxt = STATUS_UNDERFLOW;
          end
        end
      end

      // Ask for the parent, or settle at the root
      ST_UP_RD: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          raddr     = parent;
          state_nxt = ST_UP_CMP;
        end
      end

      // Stop below a parent that is not greater, else pull it down
      ST_UP_CMP: begin
        we = 1'b1;
        if (rdata_s <= k_r) begin
          state_nxt = ST_FINISH;
        end else begin
          wdata     = rdata;
          pos_nxt   = parent;
          state_nxt = ST_UP_RD;
        end
      end

      // Take the last element as the key to sink from the root
      ST_LAST: begin
        k_nxt     = rdata_s;
        pos_nxt   = '0;
        state_nxt = ST_DN_RDL;
      end

      // Ask for the left child, or settle when there is none
      ST_DN_RDL: begin
        if (left_idx >= (CW+1)'(count_r)) begin
          we        = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          raddr     = left_idx[AW-1:0];
          state_nxt = ST_DN_RDR;
        end
      end

      // Weigh the left child against the key and ask for the right one
      ST_DN_RDR: begin
        r_ok_nxt = right_idx < (CW+1)'(count_r);
        raddr    = right_idx[AW-1:0];
        if (rdata_s < k_r) begin
          best_nxt  = rdata_s;
          sm_nxt    = left_idx[AW-1:0];
          moved_nxt = 1'b1;
        end else begin
          best_nxt  = k_r;
          sm_nxt    = pos_r;
          moved_nxt = 1'b0;
        end
        state_nxt = ST_DN_CMP;
      end

      // Pick the smaller child; lift it into the hole or settle the key
      ST_DN_CMP: begin
        we = 1'b1;
        if (r_ok_r && (rdata_s < best_r)) begin
          wdata     = rdata;
          pos_nxt   = right_idx[AW-1:0];
          state_nxt = ST_DN_RDL;
        end else if (moved_r) begin
          wdata     = best_r;
          pos_nxt   = sm_r;
          state_nxt = ST_DN_RDL;
        end else begin
          state_nxt = ST_FINISH;
        end
      end

      // Issue the result
      ST_FINISH: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_r;
        out_count_nxt  = count_r;
        if (take_rem_r) begin
          out_value_nxt = rem_val_r;
        end else if (count_r == '0) begin
          out_value_nxt = '0;
        end else begin
          out_value_nxt = root_r;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  // Datapath registers; the root copy follows every write to entry zero
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    k_r          <= k_nxt;
    best_r       <= best_nxt;
    sm_r         <= sm_nxt;
    moved_r      <= moved_nxt;
    r_ok_r       <= r_ok_nxt;
    rem_val_r    <= rem_val_nxt;
    take_rem_r   <= take_rem_nxt;
    status_r     <= status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    if (we && (waddr == '0)) begin
      root_r <= $signed(wdata);
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

  // A result leaves only from the finishing step, and the block is free then
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_FINISH) && (state_r == ST_IDLE))
    else $error("result issued outside the finishing step");

  // An accepted insert that fits grows the count by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == REQ_INSERT) && !full)
      |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the count");

  // Underflow reports an empty heap and a zero value
  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STATUS_UNDERFLOW))
      |-> (out_count_r == '0) && (out_value_r == '0))
    else $error("underflow with keys held");

  // The count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (MW'(count_r) <= DEPTH_M))
    else $error("count beyond store depth");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmhq_pkg::*;

  localparam int unsigned HEAP_DEPTH = 64;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned COUNT_W    = $clog2(HEAP_DEPTH) + 1;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  // request code the block does not define; it behaves as a peek
  localparam logic [1:0] REQ_SPARE = 2'd3;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    key_t               value;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } heap_result_t;

  // Predict each result of the heap and hold the expectations in order
  class heap_result_checker;
    key_t         heap_keys[HEAP_DEPTH];
    int unsigned  held;
    int unsigned  cap_limit;
    heap_result_t awaited[$];
    int unsigned  errors;

    function new();
      held      = 0;
      cap_limit = CAP_RESET;
      errors    = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] limit);
      cap_limit = limit;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // Apply one accepted item to the model heap and queue its result
    function void note_request(logic [1:0] req, key_t key);
      heap_result_t res;
      int unsigned  pos;
      int unsigned  parent;
      int unsigned  lchild;
      int unsigned  rchild;
      int unsigned  least;
      int unsigned  eff_cap;
      key_t         moving;
      res.status = STATUS_OK;
      res.value  = '0;
      eff_cap = (cap_limit > HEAP_DEPTH) ? HEAP_DEPTH : cap_limit;
      case (req)
        REQ_INSERT: begin
          if (held >= eff_cap) begin
            res.status = STATUS_OVERFLOW;
          end else begin
            // climb while the parent is strictly greater
            pos    = held;
            moving = key;
            held++;
            while (pos != 0) begin
              parent = (pos - 1) / 2;
              if (heap_keys[parent] <= moving) break;
              heap_keys[pos] = heap_keys[parent];
              pos = parent;
            end
            heap_keys[pos] = moving;
          end
          if (held > 0) res.value = heap_keys[0];
        end
        REQ_REMOVE: begin
          if (held == 0) begin
            res.status = STATUS_UNDERFLOW;
          end else begin
            res.value = heap_keys[0];
            held--;
            if (held > 0) begin
              // move the last key to the root and sink it; left child wins a tie
              heap_keys[0] = heap_keys[held];
              pos = 0;
              forever begin
                lchild = 2 * pos + 1;
                rchild = 2 * pos + 2;
                least  = pos;
                if (lchild < held && heap_keys[lchild] < heap_keys[least]) least = lchild;
                if (rchild < held && heap_keys[rchild] < heap_keys[least]) least = rchild;
                if (least == pos) break;
                moving           = heap_keys[pos];
                heap_keys[pos]   = heap_keys[least];
                heap_keys[least] = moving;
                pos = least;
              end
            end
          end
        end
        default: begin
          if (held == 0) res.status = STATUS_UNDERFLOW;
          else res.value = heap_keys[0];
        end
      endcase
      res.count = held[COUNT_W-1:0];
      awaited.push_back(res);
    endfunction

    // Compare one result with the oldest expectation
    function void check_result(key_t value, logic [1:0] status, logic [COUNT_W-1:0] count);
      heap_result_t exp_res;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value %0d status %0d count %0d",
                 $time, value, status, count);
        return;
      end
      exp_res = awaited.pop_front();
      if (value !== exp_res.value) begin
        errors++;
        $display("%0t: value expected %0d actual %0d", $time, exp_res.value, value);
      end
      if (status !== exp_res.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status);
      end
      if (count !== exp_res.count) begin
        errors++;
        $display("%0t: count expected %0d actual %0d", $time, exp_res.count, count);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_req_type = REQ_PEEK;
  key_t               in_key = '0;
  logic               out_valid;
  key_t               out_value;
  logic [1:0]         out_status;
  logic [COUNT_W-1:0] out_count;
  logic               cfg_we = 1'b0;
  logic [CAP_W-1:0]   cfg_data = CAP_RESET;

  heap_result_checker heap_sb = new();
  int unsigned        cycles = 0;

  binary_min_heap_queue_top #(
    .DEPTH     (HEAP_DEPTH),
    .KEY_WIDTH (KEY_W)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req_type (in_req_type),
    .in_key      (in_key),
    .out_valid   (out_valid),
    .out_value   (out_value),
    .out_status  (out_status),
    .out_count   (out_count),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Take each result in the cycle it is offered
  always @(posedge clk) begin
    if (rst_n && out_valid) heap_sb.check_result(out_value, out_status, out_count);
  end

  // Abandon a run that hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Mostly short gaps, some long ones
  function automatic int unsigned pick_gap(bit no_gaps);
    int unsigned roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Keys: extremes, a narrow band to force equal keys, or the full range
  function automatic key_t pick_key();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      1, 2, 3: return key_t'(int'($urandom_range(0, 20)) - 10);
      default: return key_t'($urandom());
    endcase
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_item(logic [1:0] req, key_t key, int unsigned gap);
    start       <= 1'b1;
    in_req_type <= req;
    in_key      <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    heap_sb.note_request(req, key);
    if (gap > 0) begin
      start       <= 1'b0;
      in_req_type <= 2'($urandom());
      in_key      <= key_t'($urandom());
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait until every result is in and the block is free
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (heap_sb.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] limit);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= limit;
    @(posedge clk);
    heap_sb.set_capacity(limit);
    cfg_we <= 1'b0;
  endtask

  // Random requests weighted towards inserts by insert_pct
  task automatic run_random(int unsigned n_items, int unsigned insert_pct, bit no_gaps);
    int unsigned roll;
    logic [1:0]  req;
    for (int unsigned i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) begin
        req = REQ_INSERT;
      end else begin
        roll = $urandom_range(0, 9);
        if (roll < 7) req = REQ_REMOVE;
        else if (roll < 9) req = REQ_PEEK;
        else req = REQ_SPARE;
      end
      send_item(req, pick_key(), pick_gap(no_gaps));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty heap after reset, extremes, equal keys, then drain past empty
    send_item(REQ_PEEK, 32'sd0, pick_gap(0));
    send_item(REQ_REMOVE, 32'sd3, pick_gap(0));
    send_item(REQ_SPARE, -32'sd3, pick_gap(0));
    send_item(REQ_INSERT, 32'sd0, pick_gap(0));
    send_item(REQ_INSERT, 32'sh7FFF_FFFF, pick_gap(0));
    send_item(REQ_INSERT, 32'sh8000_0000, pick_gap(0));
    send_item(REQ_INSERT, -32'sd1, pick_gap(0));
    send_item(REQ_INSERT, 32'sd1, pick_gap(0));
    send_item(REQ_INSERT, 32'sd5, pick_gap(0));
    send_item(REQ_INSERT, 32'sd5, pick_gap(0));
    send_item(REQ_INSERT, 32'sd5, pick_gap(0));
    send_item(REQ_PEEK, 32'sh7FFF_FFFF, pick_gap(0));
    send_item(REQ_SPARE, 32'sh8000_0000, pick_gap(0));
    for (int i = 0; i < 9; i++) send_item(REQ_REMOVE, pick_key(), pick_gap(0));

    // capacity of one: second insert overflows
    write_capacity(7'd1);
    send_item(REQ_INSERT, 32'sd7, pick_gap(0));
    send_item(REQ_INSERT, 32'sd8, pick_gap(0));
    send_item(REQ_PEEK, 32'sd0, pick_gap(0));
    send_item(REQ_REMOVE, 32'sd0, pick_gap(0));
    send_item(REQ_REMOVE, 32'sd0, pick_gap(0));

    // zero capacity: every insert overflows
    write_capacity(7'd0);
    send_item(REQ_INSERT, 32'sd9, pick_gap(0));
    send_item(REQ_PEEK, 32'sd0, pick_gap(0));

    // capacity above the store saturates; fill until full and overflow
    write_capacity(7'd127);
    run_random(60, 90, 1);
    run_random(60, 80, 0);

    // lower the limit below the count held, then drain
    write_capacity(7'd10);
    run_random(60, 30, 0);

    write_capacity(CAP_RESET);
    run_random(80, 55, 0);

    write_capacity(CAP_W'($urandom_range(1, 64)));
    run_random(60, 50, 1);

    write_capacity(7'd2);
    run_random(40, 50, 0);

    write_capacity(CAP_RESET);
    run_random(70, 20, 0);

    // let any stray result show itself before the verdict
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (heap_sb.errors == 0 && heap_sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
